>>> sv/ltt_pkg.sv
// ----------------------------------------------------------------------------
// ltt_pkg: shared types and helpers for the long task timer table
// Request codes, result codes, the token handed from cell to cell, the
// broadcast request fields and the elapsed-time arithmetic.
// ----------------------------------------------------------------------------
package ltt_pkg;

  localparam int TIME_W             = 63;
  localparam int ELAPSED_W          = 64;
  localparam int ACTIVE_W           = 7;
  localparam int IN_TDATA_W         = 128;
  localparam int OUT_TDATA_W        = 200;
  localparam int DEFAULT_TASK_SLOTS = 64;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_QUERY = 2'd2,
    OP_TOTAL = 2'd3
  } ltt_op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FULL    = 2'd2
  } ltt_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } ltt_state_e;

  // Request fields held steady and seen by every cell while a token runs
  typedef struct packed {
    ltt_op_e             op;
    logic [TIME_W-1:0]   now;
    logic [TIME_W-1:0]   key;
  } ltt_bcast_t;

  // Token walking down the cell row
  typedef struct packed {
    logic                vld;
    logic                hit;
    logic [TIME_W-1:0]   elapsed;
    logic [TIME_W-1:0]   total;
    logic [TIME_W-1:0]   pend;
  } ltt_tok_t;

  // Time since start, zero when the clock reads behind the start stamp
  function automatic logic [TIME_W-1:0] elapsed_of(input logic [TIME_W-1:0] now,
                                                   input logic [TIME_W-1:0] start);
    return (now >= start) ? (now - start) : '0;
  endfunction

  // Saturating add at 2^63-1
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

>>> sv/ltt_cell.sv
// ----------------------------------------------------------------------------
// ltt_cell: one table slot
// Holds a valid bit, task key and start stamp. Claims a start or matches a
// lookup when the token passes by, and folds its elapsed time into totals.
// ----------------------------------------------------------------------------
module ltt_cell import ltt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ltt_bcast_t bcast_i,
  input  ltt_tok_t   tok_i,
  output ltt_tok_t   tok_o
);

  logic              valid_q, valid_d;
  logic [TIME_W-1:0] slot_key_q, slot_key_d;
  logic [TIME_W-1:0] slot_start_q, slot_start_d;
  ltt_tok_t          tok_q, tok_d;
  logic [TIME_W-1:0] elapsed;

  // Slot update and token hand-off
  always_comb begin
    valid_d      = valid_q;
    slot_key_d   = slot_key_q;
    slot_start_d = slot_start_q;
    tok_d        = tok_i;
    elapsed      = elapsed_of(bcast_i.now, slot_start_q);
    if (tok_i.vld) begin
      case (bcast_i.op)
        OP_START: begin
          if (!tok_i.hit && !valid_q) begin
            valid_d      = 1'b1;
            slot_key_d   = bcast_i.key;
            slot_start_d = bcast_i.now;
            tok_d.hit    = 1'b1;
          end
        end
        OP_STOP, OP_QUERY: begin
          if (!tok_i.hit && valid_q && (slot_key_q == bcast_i.key)) begin
            tok_d.hit     = 1'b1;
            tok_d.elapsed = elapsed;
            if (bcast_i.op == OP_STOP) begin
              valid_d = 1'b0;
            end
          end
        end
        OP_TOTAL: begin
          // add the previous cell's share, hand on our own
          tok_d.total = sat_add(tok_i.total, tok_i.pend);
          tok_d.pend  = valid_q ? elapsed : '0;
        end
        default: ;
      endcase
    end
  end

  // Slot and token registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      slot_key_q   <= '0;
      slot_start_q <= '0;
      tok_q        <= '0;
    end else begin
      valid_q      <= valid_d;
      slot_key_q   <= slot_key_d;
      slot_start_q <= slot_start_d;
      tok_q        <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> sv/ltt_ctrl.sv
// ----------------------------------------------------------------------------
// ltt_ctrl: request intake, key and count bookkeeping, result register
// Latches a request, launches a token into the cell row, collects it at the
// far end and builds the result in an output register.
// ----------------------------------------------------------------------------
module ltt_ctrl import ltt_pkg::*; #(
  parameter int TASK_SLOTS = DEFAULT_TASK_SLOTS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output ltt_bcast_t             bcast_o,
  output ltt_tok_t               tok_o,
  input  ltt_tok_t               tok_i
);

  localparam int CNT_W = $clog2(TASK_SLOTS + 1);

  ltt_state_e                  state_q, state_d;
  ltt_bcast_t                  req_q, req_d;
  logic                        launch_q, launch_d;
  ltt_tok_t                    fin_q, fin_d;
  logic [TIME_W-1:0]           next_key_q, next_key_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        out_vld_q, out_vld_d;
  logic [OUT_TDATA_W-1:0]      out_q, out_d;
  logic                        in_req;
  logic                        out_free;
  ltt_status_e                 status;
  logic [TIME_W-1:0]           assigned;
  logic signed [ELAPSED_W-1:0] elapsed;
  logic [TIME_W-1:0]           total;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;

  // Next state, bookkeeping and result build
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    launch_d   = 1'b0;
    fin_d      = fin_q;
    next_key_d = next_key_q;
    cnt_d      = cnt_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_d      = out_q;
    status     = ST_OK;
    assigned   = '0;
    elapsed    = '0;
    total      = '0;

    case (fin_q.vld ? ltt_op_e'(req_q.op) : OP_TOTAL)
      OP_START: begin
        if (fin_q.hit) begin
          assigned = req_q.key;
        end else begin
          status = ST_FULL;
        end
      end
      OP_STOP, OP_QUERY: begin
        if (fin_q.hit) begin
          elapsed = {1'b0, fin_q.elapsed};
        end else begin
          status  = ST_UNKNOWN;
          elapsed = '1;
        end
      end
      OP_TOTAL: total = sat_add(fin_q.total, fin_q.pend);
      default: ;
    endcase

    case (state_q)
      S_IDLE: begin
        if (in_req) begin
          req_d.op  = ltt_op_e'(s_axis_tuser);
          req_d.now = s_axis_tdata[TIME_W-1:0];
          req_d.key = (ltt_op_e'(s_axis_tuser) == OP_START) ?
                      next_key_q : s_axis_tdata[2*TIME_W-1:TIME_W];
          launch_d  = 1'b1;
          state_d   = S_RUN;
        end
      end
      S_RUN: begin
        if (tok_i.vld) begin
          fin_d   = tok_i;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          if (req_q.op == OP_START && fin_q.hit) begin
            next_key_d = next_key_q + TIME_W'(1);
            cnt_d      = cnt_q + CNT_W'(1);
          end else if (req_q.op == OP_STOP && fin_q.hit && cnt_q != '0) begin
            cnt_d      = cnt_q - CNT_W'(1);
          end
          out_vld_d = 1'b1;
          out_d     = {1'b0, total, ACTIVE_W'(cnt_d), elapsed, assigned, status};
          fin_d.vld = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      launch_q   <= 1'b0;
      fin_q      <= '0;
      next_key_q <= '0;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      launch_q   <= launch_d;
      fin_q      <= fin_d;
      next_key_q <= next_key_d;
      cnt_q      <= cnt_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q         <= req_d;
    out_q         <= out_d;
  end

  // Token entering the first cell
  always_comb begin
    tok_o         = '0;
    tok_o.vld     = launch_q;
  end

  assign bcast_o       = req_q;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

>>> sv/long_task_timer_table.sv
// Flow: an accepted request launches a token that walks the cell row one slot per
// cycle; the controller captures it at the far end and then registers the result.
// A new request is taken only once that result is built, and later while a
// finished result waits on a full output register.
// Reset: asynchronous, active low; all slots free, next key and count zero.
// ----------------------------------------------------------------------------
// long_task_timer_table: running task table with elapsed-time queries
// A row of slot cells visited in order by a request token, plus a controller
// for intake, key assignment, active count and result.
// ----------------------------------------------------------------------------
module long_task_timer_table import ltt_pkg::*; #(
  parameter int TASK_SLOTS = DEFAULT_TASK_SLOTS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [62:0] now_time, [125:63] task_key, [127:126] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [1:0] status, [64:2] assigned_task, [128:65] elapsed,
  // [135:129] active_tasks, [198:136] run total, [199] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  ltt_bcast_t bcast;
  ltt_tok_t   tok [TASK_SLOTS+1];

  ltt_ctrl #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .bcast_o       (bcast),
    .tok_o         (tok[0]),
    .tok_i         (tok[TASK_SLOTS])
  );

  // Slot row, lowest slot first
  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    ltt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bcast_i (bcast),
      .tok_i   (tok[i]),
      .tok_o   (tok[i+1])
    );
  end

endmodule

>>> sv/ltt_checker.sv
// ----------------------------------------------------------------------------
// ltt_checker: port-level checks for the long task timer table
// Watches requests and results on the top level ports.
// ----------------------------------------------------------------------------
module ltt_checker import ltt_pkg::*; #(
  parameter int TASK_SLOTS = DEFAULT_TASK_SLOTS
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [1:0]             s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one request in flight: intake closes right after a request
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while busy");

  // status code is never the unused one
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("bad status code");

  // unknown key reports elapsed of minus one
  a_unknown_elapsed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == ST_UNKNOWN |-> &m_axis_tdata[128:65])
    else $error("unknown key without elapsed of minus one");

  // full table: no key given and the count shows every slot busy
  a_full_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == ST_FULL |->
      m_axis_tdata[64:2] == '0 && m_axis_tdata[135:129] == ACTIVE_W'(TASK_SLOTS))
    else $error("full status with bad key or count");

endmodule

bind long_task_timer_table ltt_checker #(
  .TASK_SLOTS (TASK_SLOTS)
) u_ltt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
